// File: rtl/core/fba_pkg.sv
// Shared constants and types of the frame bitmap allocator.
`default_nettype none
package fba_pkg;

  // Default geometry and register reset value.
  localparam int FRAME_COUNT_DEF = 32768;
  localparam int FRAME_BYTES_DEF = 4096;
  localparam logic [15:0] RESERVED_RESET = 16'd8192;

  // Frames held in one bitmap word.
  localparam int WORD_BITS = 32;

  // Command codes.
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_ALLOC  = 3'd1;
  localparam logic [2:0] OP_FREE   = 3'd2;
  localparam logic [2:0] OP_INCREF = 3'd3;
  localparam logic [2:0] OP_DECREF = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_RD,
    S_INIT_BIT,
    S_SCAN,
    S_FIND,
    S_MOD,
    S_RESULT
  } fsm_state_t;

endpackage
`default_nettype wire

// File: rtl/core/frame_bitmap_refcount_allocator.sv
// Top level of the physical frame allocator with bitmap and owner counts.
//
// One command is taken at a time and in_ready is high only while the sequencer
// is idle; a finished result may still wait in the output register meanwhile.
// Free, incref, decref and read pass through S_MOD to S_RESULT; an unused
// command or an out-of-range address goes straight to S_RESULT. Alloc scans
// the bitmap RAM one 32-frame word per cycle and then steps through the
// found word one bit per cycle. Init walks the reserved frames one per
// cycle, writing each owner count, with a read step in S_INIT_RD before
// each bitmap word. After reset a clearing pass zeroes the bitmap RAM
// before the first command is taken; configuration writes are accepted
// throughout. Each bitmap word keeps 32 used bits and 32 count-valid bits,
// so the owner count RAM itself is never cleared: a count whose valid bit
// is clear reads as zero. FRAME_BYTES must be a power of two.
`default_nettype none
module frame_bitmap_refcount_allocator
  import fba_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [31:0] address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [26:0]      frame_address,
  output logic [15:0]      owner_count,
  output logic [15:0]      free_count
);

  // Geometry derived from the parameters.
  localparam int WORDS       = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW         = $clog2(WORDS);
  localparam int BW          = $clog2(WORD_BITS);
  localparam int FIW         = WAW + BW;
  localparam int FTW         = $clog2(FRAME_COUNT + 1);
  localparam int RW          = (FTW > 16) ? FTW : 16;
  localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
  localparam int LAST_VALID  = FRAME_COUNT - (WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_PAD =
    (LAST_VALID == WORD_BITS) ? '0 :
    ~((WORD_BITS'(1) << LAST_VALID) - WORD_BITS'(1));

  // Configuration register.
  logic [15:0] reserved_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_frames <= RESERVED_RESET;
    end else if (cfg_we) begin
      reserved_frames <= cfg_wdata;
    end
  end

  // Sequencer and working registers.
  fsm_state_t state, state_next;
  logic [WAW-1:0]         word_idx, word_idx_next;
  logic [BW-1:0]          bit_idx, bit_idx_next;
  logic [2*WORD_BITS-1:0] word_reg, word_reg_next;
  logic [2:0]             op_reg, op_reg_next;
  logic [FIW-1:0]         frame_reg, frame_reg_next;
  logic [FTW-1:0]         init_limit, init_limit_next;
  logic [FTW-1:0]         free_total;
  logic [1:0]             res_status, res_status_next;
  logic [26:0]            res_faddr, res_faddr_next;
  logic [15:0]            res_count, res_count_next;
  logic                   ft_up, ft_down;

  // RAM ports.
  logic                   bm_we;
  logic [WAW-1:0]         bm_waddr, bm_raddr;
  logic [2*WORD_BITS-1:0] bm_wdata, bm_rdata;
  logic                   cnt_we;
  logic [FIW-1:0]         cnt_waddr, cnt_raddr;
  logic [15:0]            cnt_wdata, cnt_rdata;

  // Used bits and count-valid bits of every frame, one word per 32 frames.
  fba_ram #(
    .WIDTH (2 * WORD_BITS),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  // Owner count of every frame.
  fba_ram #(
    .WIDTH (16),
    .DEPTH (FRAME_COUNT)
  ) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Decode of the incoming address and of the current frame position.
  logic [31:0]          in_frame;
  logic                 in_bad;
  logic [RW-1:0]        reserved_ext;
  logic [FIW-1:0]       cur_frame;
  logic [FTW-1:0]       cur_frame_inc;
  logic [WORD_BITS-1:0] bit_hot, frame_hot;
  logic [WORD_BITS-1:0] scan_used;
  logic [63:0]          faddr_wide;
  logic                 mod_used, mod_cvalid;
  logic [15:0]          mod_count;

  assign in_frame      = address >> FRAME_SHIFT;
  assign in_bad        = (in_frame >= 32'(FRAME_COUNT));
  assign reserved_ext  = RW'(reserved_frames);
  assign cur_frame     = {word_idx, bit_idx};
  assign cur_frame_inc = FTW'(cur_frame) + FTW'(1);
  assign bit_hot       = WORD_BITS'(1) << bit_idx;
  assign frame_hot     = WORD_BITS'(1) << frame_reg[BW-1:0];
  assign faddr_wide    = 64'(cur_frame) << FRAME_SHIFT;
  assign scan_used     = bm_rdata[WORD_BITS-1:0] |
                         ((word_idx == WAW'(WORDS - 1)) ? LAST_PAD : '0);
  assign mod_used      = bm_rdata[frame_reg[BW-1:0]];
  assign mod_cvalid    = bm_rdata[WORD_BITS + int'(frame_reg[BW-1:0])];
  assign mod_count     = mod_cvalid ? cnt_rdata : 16'd0;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, RAM control and working values.
  always_comb begin
    state_next      = state;
    word_idx_next   = word_idx;
    bit_idx_next    = bit_idx;
    word_reg_next   = word_reg;
    op_reg_next     = op_reg;
    frame_reg_next  = frame_reg;
    init_limit_next = init_limit;
    res_status_next = res_status;
    res_faddr_next  = res_faddr;
    res_count_next  = res_count;
    ft_up           = 1'b0;
    ft_down         = 1'b0;
    bm_we           = 1'b0;
    bm_waddr        = word_idx;
    bm_wdata        = word_reg;
    bm_raddr        = word_idx;
    cnt_we          = 1'b0;
    cnt_waddr       = cur_frame;
    cnt_wdata       = 16'd1;
    cnt_raddr       = frame_reg;
    in_ready        = 1'b0;

    case (state)
      // Zero one bitmap word per cycle after reset.
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_wdata = '0;
        if (word_idx == WAW'(WORDS - 1)) begin
          word_idx_next = '0;
          state_next    = S_IDLE;
        end else begin
          word_idx_next = word_idx + WAW'(1);
        end
      end

      // Take a command and start the reads it needs.
      S_IDLE: begin
        in_ready        = 1'b1;
        word_idx_next   = '0;
        bit_idx_next    = '0;
        bm_raddr        = '0;
        cnt_raddr       = in_frame[FIW-1:0];
        if (in_valid) begin
          op_reg_next     = op;
          frame_reg_next  = in_frame[FIW-1:0];
          res_status_next = ST_OK;
          res_faddr_next  = '0;
          res_count_next  = '0;
          if (reserved_ext > RW'(FRAME_COUNT)) begin
            init_limit_next = FTW'(FRAME_COUNT);
          end else begin
            init_limit_next = FTW'(reserved_ext);
          end
          case (op)
            OP_INIT: begin
              state_next = (reserved_frames == 16'd0) ? S_RESULT : S_INIT_RD;
            end
            OP_ALLOC: begin
              state_next = S_SCAN;
            end
            OP_FREE, OP_INCREF, OP_DECREF, OP_READ: begin
              bm_raddr = in_frame[FIW-1:BW];
              if (in_bad) begin
                res_status_next = ST_BAD_ADDR;
                state_next      = S_RESULT;
              end else begin
                state_next = S_MOD;
              end
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end

      // Init: capture the bitmap word about to be reserved.
      S_INIT_RD: begin
        word_reg_next = bm_rdata;
        state_next    = S_INIT_BIT;
      end

      // Init: reserve one frame per cycle and write back each finished word.
      S_INIT_BIT: begin
        cnt_we        = 1'b1;
        cnt_wdata     = 16'd1;
        ft_down       = ~word_reg[bit_idx];
        word_reg_next = word_reg | {bit_hot, bit_hot};
        bm_wdata      = word_reg_next;
        bm_raddr      = word_idx + WAW'(1);
        bit_idx_next  = bit_idx + BW'(1);
        if (cur_frame_inc == init_limit) begin
          bm_we      = 1'b1;
          state_next = S_RESULT;
        end else if (bit_idx == BW'(WORD_BITS - 1)) begin
          bm_we         = 1'b1;
          word_idx_next = word_idx + WAW'(1);
          state_next    = S_INIT_RD;
        end
      end

      // Alloc: look for a word with a free frame, one word per cycle.
      S_SCAN: begin
        bm_raddr = word_idx + WAW'(1);
        if (~&scan_used) begin
          word_reg_next = {bm_rdata[2*WORD_BITS-1:WORD_BITS], scan_used};
          bit_idx_next  = '0;
          state_next    = S_FIND;
        end else if (word_idx == WAW'(WORDS - 1)) begin
          res_status_next = ST_NO_FREE;
          state_next      = S_RESULT;
        end else begin
          word_idx_next = word_idx + WAW'(1);
        end
      end

      // Alloc: step through the word to the lowest free frame and take it.
      S_FIND: begin
        if (!word_reg[bit_idx]) begin
          bm_we          = 1'b1;
          bm_wdata       = word_reg | {bit_hot, bit_hot};
          cnt_we         = 1'b1;
          cnt_wdata      = 16'd1;
          ft_down        = 1'b1;
          res_faddr_next = faddr_wide[26:0];
          res_count_next = 16'd1;
          state_next     = S_RESULT;
        end else begin
          bit_idx_next = bit_idx + BW'(1);
        end
      end

      // Free, incref, decref and read on the addressed frame.
      S_MOD: begin
        bm_waddr   = frame_reg[FIW-1:BW];
        cnt_waddr  = frame_reg;
        state_next = S_RESULT;
        case (op_reg)
          OP_FREE: begin
            bm_we    = 1'b1;
            bm_wdata = bm_rdata & ~{frame_hot, frame_hot};
            ft_up    = mod_used;
          end
          OP_INCREF: begin
            bm_we          = 1'b1;
            bm_wdata       = bm_rdata | {frame_hot, {WORD_BITS{1'b0}}};
            cnt_we         = 1'b1;
            cnt_wdata      = (mod_count == 16'hFFFF) ? mod_count : mod_count + 16'd1;
            res_count_next = cnt_wdata;
          end
          OP_DECREF: begin
            bm_we          = 1'b1;
            cnt_we         = 1'b1;
            cnt_wdata      = (mod_count != 16'd0) ? mod_count - 16'd1 : 16'd0;
            res_count_next = cnt_wdata;
            if (cnt_wdata == 16'd0) begin
              bm_wdata = (bm_rdata | {frame_hot, {WORD_BITS{1'b0}}}) &
                         ~{{WORD_BITS{1'b0}}, frame_hot};
              ft_up    = mod_used;
            end else begin
              bm_wdata = bm_rdata | {frame_hot, {WORD_BITS{1'b0}}};
            end
          end
          default: begin
            res_count_next = mod_count;
          end
        endcase
      end

      // Post the result once the output register is free.
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Working registers; the word index also drives the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_idx <= '0;
    end else begin
      word_idx <= word_idx_next;
    end
    bit_idx    <= bit_idx_next;
    word_reg   <= word_reg_next;
    op_reg     <= op_reg_next;
    frame_reg  <= frame_reg_next;
    init_limit <= init_limit_next;
    res_status <= res_status_next;
    res_faddr  <= res_faddr_next;
    res_count  <= res_count_next;
  end

  // Free frame counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_total <= FTW'(FRAME_COUNT);
    end else if (ft_up) begin
      free_total <= free_total + FTW'(1);
    end else if (ft_down) begin
      free_total <= free_total - FTW'(1);
    end
  end

  // Output register.
  logic [31:0] free_wide;
  assign free_wide = 32'(free_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESULT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && (!out_valid || out_ready)) begin
      status        <= res_status;
      frame_address <= res_faddr;
      owner_count   <= res_count;
      free_count    <= free_wide[15:0];
    end
  end

`ifndef SYNTHESIS
  // The free counter never exceeds the number of frames.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= FTW'(FRAME_COUNT))
    else $error("free frame counter above frame count");

  // An accepted command always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE && state != S_CLEAR))
    else $error("accepted command did not start");

  // The bit search only runs on a word that holds a free frame.
  a_find_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND && bit_idx == BW'(WORD_BITS - 1)) |-> !word_reg[WORD_BITS-1])
    else $error("bit search ran past the end of the word");

  // A failed alloc reports no frame, a zero count and no free frames left.
  a_no_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NO_FREE) |->
      (free_count == 16'd0 || FTW > 16) && frame_address == '0 && owner_count == '0)
    else $error("failed alloc with frames left or nonzero fields");

  // A rejected address reports a zero count.
  a_bad_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_BAD_ADDR) |-> owner_count == 16'd0)
    else $error("out-of-range address with nonzero count");
`endif

endmodule
`default_nettype wire

// File: rtl/core/fba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
